[sv/cif_pkg.sv]
package cif_pkg;

  // defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int PIXEL_BITS_DEF = 16;

  // fixed field widths
  localparam int PIX_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SUM_W      = 28;  // 9 taps * 16b unsigned * 8b signed
  localparam int WS_W       = 12;  // 9 * +/-128
  localparam int DVD_W      = 27;  // magnitude of the sum
  localparam int DVS_W      = 11;  // magnitude of the weight sum
  localparam int TAP_IDX_W  = 4;
  localparam int DIV_CNT_W  = 5;
  localparam int Q_DEPTH    = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOT     = 3'd6;

  typedef struct packed {
    logic [11:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_value;
    logic        normalize;
    logic [23:0] coef_top;
    logic [23:0] coef_mid;
    logic [23:0] coef_bot;
  } cfg_t;

  // one window position handed from front to back
  typedef struct packed {
    logic [8:0][PIX_W-1:0] tap;     // row-major, top-left at index 0
    logic [8:0]            tap_en;  // tap lies inside the image
    logic                  eor;
    logic                  eof;
  } job_t;

  // kernel coefficient for a row-major tap index
  function automatic logic signed [7:0] coef_of(cfg_t c, logic [TAP_IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = c.coef_top[7:0];
      4'd1:    b = c.coef_top[15:8];
      4'd2:    b = c.coef_top[23:16];
      4'd3:    b = c.coef_mid[7:0];
      4'd4:    b = c.coef_mid[15:8];
      4'd5:    b = c.coef_mid[23:16];
      4'd6:    b = c.coef_bot[7:0];
      4'd7:    b = c.coef_bot[15:8];
      4'd8:    b = c.coef_bot[23:16];
      default: b = 8'd0;
    endcase
    return $signed(b);
  endfunction

endpackage

[sv/cif_front.sv]
module cif_front
  import cif_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             restart,
  input  logic             in_valid,
  input  logic             in_flush,
  input  logic [PIX_W-1:0] in_pixel,
  output logic             in_ready,
  input  logic             q_full,
  output logic             job_push,
  output job_t             job
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > 12) ? WW : 12;
  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 1);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_PROC = 2'b10
  } fstate_t;

  fstate_t          st_r, st_nxt;
  logic [AW-1:0]    in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [15:0]      in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [PIX_W-1:0] pix_r;
  logic [PIX_W-1:0] rd_up_r, rd_lo_r;
  logic [PIX_W-1:0] win_r [9];
  logic [PIX_W-1:0] mem_up [MAX_WIDTH];
  logic [PIX_W-1:0] mem_lo [MAX_WIDTH];
  logic [PIX_W-1:0] col_in [3];

  logic [CMPW-1:0]  w_ext, w_eff;
  logic [15:0]      h_eff;
  logic             accept, drop, go, emit, eor, eof;
  logic             in_last_col;

  // effective geometry
  always_comb begin
    w_ext = CMPW'(cfg.image_width);
    if (w_ext == '0) begin
      w_eff = CMPW'(1);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
  end

  // input handshake; a flush before any pixel of a frame is dropped
  assign in_ready = (st_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign drop     = in_flush && (in_row_r == 16'd0) && (in_col_r == '0);
  assign go       = accept && !drop;

  assign col_in[0] = rd_up_r;
  assign col_in[1] = rd_lo_r;
  assign col_in[2] = pix_r;

  assign emit = (in_row_r > 16'd1) || ((in_row_r == 16'd1) && (in_col_r != '0));
  assign eor  = (CMPW'(out_col_r) + CMPW'(1)) >= w_eff;
  assign eof  = eor && (({1'b0, out_row_r} + 17'd1) >= {1'b0, h_eff});
  assign in_last_col = (CMPW'(in_col_r) + CMPW'(1)) >= w_eff;

  // job for the back part: two held window columns plus the incoming column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      job.tap[k*3]   = win_r[k*3];
      job.tap[k*3+1] = win_r[k*3 + 1];
      job.tap[k*3+2] = col_in[k];
    end
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        job.tap_en[k*3+j] =
          ((k != 0) || (out_row_r != 16'd0)) &&
          ((k != 2) || (({1'b0, out_row_r} + 17'd1) < {1'b0, h_eff})) &&
          ((j != 0) || (out_col_r != '0)) &&
          ((j != 2) || !eor);
      end
    end
    job.eor = eor;
    job.eof = eof;
  end

  assign job_push = (st_r == F_PROC) && emit;

  // next state and position counters
  always_comb begin
    st_nxt      = st_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    unique case (st_r)
      F_IDLE: begin
        if (go) begin
          st_nxt = F_PROC;
        end
      end
      F_PROC: begin
        st_nxt = F_IDLE;
        if (emit) begin
          if (eor) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + 16'd1;
          end else begin
            out_col_nxt = out_col_r + AW'(1);
          end
        end
        if (in_last_col) begin
          in_col_nxt = '0;
          if (in_row_r != 16'hFFFF) begin
            in_row_nxt = in_row_r + 16'd1;
          end
        end else begin
          in_col_nxt = in_col_r + AW'(1);
        end
        if (emit && eof) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= F_IDLE;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      st_r      <= st_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // latch the pixel; a flush acts as a zero pixel
  always_ff @(posedge clk) begin
    if (go) begin
      pix_r <= in_flush ? '0 : (in_pixel & PIX_MASK);
    end
  end

  // line stores: read on accept, write back in the following cycle
  always_ff @(posedge clk) begin
    if (go) begin
      rd_up_r <= mem_up[in_col_r];
      rd_lo_r <= mem_lo[in_col_r];
    end
    if (st_r == F_PROC) begin
      mem_up[in_col_r] <= rd_lo_r;
      mem_lo[in_col_r] <= pix_r;
    end
  end

  // 3x3 window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (st_r == F_PROC) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]   <= win_r[k*3 + 1];
        win_r[k*3+1] <= win_r[k*3 + 2];
        win_r[k*3+2] <= col_in[k];
      end
    end
  end

endmodule

[sv/cif_queue.sv]
module cif_queue
  import cif_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic empty,
  output logic full
);

  localparam int PW = $clog2(Q_DEPTH);

  job_t          q_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (PW+1)'(Q_DEPTH));
  assign head_job = q_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(Q_DEPTH))
    else $error("queue level out of range");

  a_level_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !empty)
    else $error("queue lost a pushed item");

endmodule

[sv/cif_back.sv]
module cif_back
  import cif_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_empty,
  input  job_t             head_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_pixel,
  output logic             out_eor,
  output logic             out_eof
);

  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 1);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MAC  = 5'b00010,
    B_CHK  = 5'b00100,
    B_DIV  = 5'b01000,
    B_OUT  = 5'b10000
  } bstate_t;

  bstate_t                 st_r;
  job_t                    job_r;
  logic [TAP_IDX_W-1:0]    idx_r;
  logic signed [SUM_W-1:0] acc_r;
  logic signed [WS_W-1:0]  wsum_r;
  logic [DVD_W-1:0]        dq_r, res_r;
  logic [DVS_W-1:0]        dvs_r, rem_r;
  logic [DIV_CNT_W-1:0]    cnt_r;
  logic                    out_valid_r, out_eor_r, out_eof_r;
  logic [PIX_W-1:0]        out_pixel_r;

  logic signed [7:0]       coef;
  logic signed [24:0]      prod;
  logic [DVS_W:0]          rem_sh;
  logic                    ge;
  logic [SUM_W-1:0]        acc_neg;
  logic [WS_W-1:0]         wsum_neg;
  logic [PIX_W-1:0]        lim;
  logic                    out_free;

  assign pop = (st_r == B_IDLE) && !q_empty;

  // one tap per cycle through a single multiplier
  assign coef = coef_of(cfg, idx_r);
  assign prod = $signed({1'b0, job_r.tap[idx_r]}) * coef;

  // restoring division step
  assign rem_sh = {rem_r, dq_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  assign acc_neg  = -acc_r;
  assign wsum_neg = -wsum_r;

  // clamp bound
  assign lim      = (cfg.max_value < PIX_MASK) ? cfg.max_value : PIX_MASK;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // output register: load a new result or drop the accepted one
      if ((st_r == B_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        B_IDLE: begin
          if (!q_empty) begin
            st_r <= B_MAC;
          end
        end
        B_MAC: begin
          if (idx_r == TAP_IDX_W'(8)) begin
            st_r <= B_CHK;
          end
        end
        B_CHK: begin
          if (cfg.normalize &&
              (((acc_r > 0) && (wsum_r > 0)) || ((acc_r < 0) && (wsum_r < 0)))) begin
            st_r <= B_DIV;
          end else begin
            st_r <= B_OUT;
          end
        end
        B_DIV: begin
          if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
            st_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      B_IDLE: begin
        job_r  <= head_job;
        idx_r  <= '0;
        acc_r  <= '0;
        wsum_r <= '0;
      end
      B_MAC: begin
        if (job_r.tap_en[idx_r]) begin
          acc_r  <= acc_r + SUM_W'(prod);
          wsum_r <= wsum_r + WS_W'(coef);
        end
        idx_r <= idx_r + TAP_IDX_W'(1);
      end
      B_CHK: begin
        rem_r <= '0;
        cnt_r <= '0;
        dq_r  <= acc_r[SUM_W-1] ? acc_neg[DVD_W-1:0] : acc_r[DVD_W-1:0];
        dvs_r <= wsum_r[WS_W-1] ? wsum_neg[DVS_W-1:0] : wsum_r[DVS_W-1:0];
        // raw mode or a non-positive quotient
        if (!cfg.normalize && (acc_r > 0)) begin
          res_r <= acc_r[DVD_W-1:0];
        end else begin
          res_r <= '0;
        end
      end
      B_DIV: begin
        rem_r <= ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
        dq_r  <= {dq_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
          res_r <= {dq_r[DVD_W-2:0], ge};
        end
      end
      B_OUT: begin
        if (out_free) begin
          out_pixel_r <= (res_r > DVD_W'(lim)) ? lim : res_r[PIX_W-1:0];
          out_eor_r   <= job_r.eor;
          out_eof_r   <= job_r.eof;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_eor   = out_eor_r;
  assign out_eof   = out_eof_r;

endmodule

[sv/conv3x3_image_filter.sv]
// 3x3 convolution over a raster stream of grey pixels.
// Input channel in_*: one item per pixel in raster order; in_tuser marks a
// flush item that carries no pixel and only drains pending positions.
// Output channel out_*: one filtered pixel per image position, tlast at the
// end of each row, tuser at the end of the frame. Results trail the input
// by image_width+1 items; after the last pixel send image_width+1 flushes.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; writing
// the width or height restarts the frame. Write only while the block idles.
// The front cannot take a new item until it has written back the last one
// (line store read, then write-back). The back works on one result at a
// time, through the one-tap-per-cycle MAC and, in normalize mode when sum
// and weight sum are nonzero and of one sign, the bit-serial divider.
// A 2-entry queue sits between them.
// Reset (rst_n low, synchronous): counters, window and queue clear; the
// line stores keep old contents and are rewritten before use.
// When out_tready is low, the result holds in the output register; the back
// and then the queue fill, and in_tready drops once the queue is full.
module conv3x3_image_filter
  import cif_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // pixel_in
  input  logic                  in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // pixel_out
  output logic                  out_tlast,  // end_of_row
  output logic                  out_tuser,  // end_of_frame
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic restart;
  logic q_full, q_empty, push, pop;
  job_t push_job, head_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= 12'd2048;
      cfg_r.image_height <= 16'd1;
      cfg_r.max_value    <= 16'd255;
      cfg_r.normalize    <= 1'b0;
      cfg_r.coef_top     <= 24'd0;
      cfg_r.coef_mid     <= 24'd65536;
      cfg_r.coef_bot     <= 24'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_wdata[11:0];
        CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata[15:0];
        CFG_MAX_VALUE:    cfg_r.max_value    <= cfg_wdata[15:0];
        CFG_NORMALIZE:    cfg_r.normalize    <= cfg_wdata[0];
        CFG_COEF_TOP:     cfg_r.coef_top     <= cfg_wdata;
        CFG_COEF_MID:     cfg_r.coef_mid     <= cfg_wdata;
        CFG_COEF_BOT:     cfg_r.coef_bot     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // geometry writes restart the frame
  assign restart = cfg_we &&
                   ((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT));

  cif_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .restart  (restart),
    .in_valid (in_tvalid),
    .in_flush (in_tuser),
    .in_pixel (in_tdata),
    .in_ready (in_tready),
    .q_full   (q_full),
    .job_push (push),
    .job      (push_job)
  );

  cif_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  cif_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata),
    .out_eor   (out_tlast),
    .out_eof   (out_tuser)
  );

endmodule
